// File: design/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types and constants for the HTML entity decoder: the classified
// word that moves from the front queue to the scanner, and the name table.
// ----------------------------------------------------------------------------
package hed_pkg;

  typedef logic [7:0] byte_t;

  // classified input word
  typedef struct packed {
    byte_t      data;
    logic       last;
    logic       is_amp;
    logic       is_semi;
    logic       is_hash;
    logic       is_x;
    logic       is_dig;
    logic [3:0] dig;
    logic [3:0] hexv;
  } item_t;

  // scanner occupancy, sized for the largest window
  typedef struct packed {
    logic [4:0] sofs;
    logic [4:0] eofs;
  } stat_t;

  localparam byte_t CH_AMP    = 8'h26;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_HASH   = 8'h23;
  localparam byte_t CODE_SAT  = 8'd128;

  localparam int NAME_NUM = 6;
  localparam int NAME_MAX = 4;

  localparam logic [2:0] NAME_LEN [NAME_NUM] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4};

  localparam byte_t NAME_CHAR [NAME_NUM][NAME_MAX] = '{
    '{"a", "m", "p", 8'h00},
    '{"l", "t", 8'h00, 8'h00},
    '{"g", "t", 8'h00, 8'h00},
    '{"q", "u", "o", "t"},
    '{"a", "p", "o", "s"},
    '{"n", "b", "s", "p"}
  };

  localparam byte_t NAME_VAL [NAME_NUM] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20};

endpackage

// File: design/html_entity_decoder_core.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_core
// Streaming HTML entity decoder: bytes in, bytes out with entities replaced.
// ----------------------------------------------------------------------------
// Plain text runs at one word per cycle when the output side is free. A failed
// entity match sends '&' out and rescans the held name bytes from the scanner
// window. A '&' among the rescanned bytes can open an entity that fails again,
// so one rescan can lead to another in such a burst. A word marked last
// flushes any unfinished entity one byte per cycle while the output is not
// stalled, and the final output word carries out_last. The two-entry input
// queue absorbs up to two words while the scanner is busy or the output is
// stalled.
module html_entity_decoder_core #(
  parameter int ENTITY_WINDOW = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic           q_valid;
  logic           q_pop;
  hed_pkg::item_t q_item;
  hed_pkg::stat_t stat;

  hed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  hed_back #(
    .ENTITY_WINDOW (ENTITY_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .stat      (stat)
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    stat.sofs <= stat.eofs)
    else $error("scan position beyond window end");

  a_window_fill: assert property (@(posedge clk) disable iff (!rst_n)
    stat.eofs <= 5'(ENTITY_WINDOW))
    else $error("window overfilled");

endmodule

// File: design/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front
// Input side: takes words, classifies each byte (delimiters, decimal and
// hex digit values) and holds them in a two-entry queue for the scanner.
// ----------------------------------------------------------------------------
module hed_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               q_valid,
  output hed_pkg::item_t     q_item,
  input  logic               q_pop
);

  hed_pkg::item_t cls;
  hed_pkg::item_t fifo_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic [7:0]     d_num;
  logic [7:0]     d_low;
  logic [7:0]     d_up;

  always_comb begin
    d_num          = in_byte - 8'h30;
    d_low          = in_byte - 8'h57;
    d_up           = in_byte - 8'h37;
    cls.data       = in_byte;
    cls.last       = in_last;
    cls.is_amp     = (in_byte == hed_pkg::CH_AMP);
    cls.is_semi    = (in_byte == hed_pkg::CH_SEMI);
    cls.is_hash    = (in_byte == hed_pkg::CH_HASH);
    cls.is_x       = (in_byte == "x") || (in_byte == "X");
    cls.is_dig     = (in_byte >= "0") && (in_byte <= "9");
    cls.dig        = cls.is_dig ? d_num[3:0] : 4'd0;
    if (cls.is_dig) begin
      cls.hexv = d_num[3:0];
    end else if ((in_byte >= "a") && (in_byte <= "f")) begin
      cls.hexv = d_low[3:0];
    end else if ((in_byte >= "A") && (in_byte <= "F")) begin
      cls.hexv = d_up[3:0];
    end else begin
      cls.hexv = 4'd0;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: design/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back
// Scanner: one byte a cycle from the queue or the rescan window, unless the
// output stalls. Holds the open entity in a circular window, matches names
// and numeric codes incrementally, rescans on failure, flushes on a last word.
// ----------------------------------------------------------------------------
module hed_back #(
  parameter int ENTITY_WINDOW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hed_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output hed_pkg::stat_t     stat
);

  localparam int PW = $clog2(ENTITY_WINDOW);
  localparam int OW = $clog2(ENTITY_WINDOW + 1);

  function automatic logic [PW-1:0] wrap(input logic [OW:0] s);
    logic [OW:0] t;
    t = s - (OW+1)'(ENTITY_WINDOW);
    if (s >= (OW+1)'(ENTITY_WINDOW)) begin
      return t[PW-1:0];
    end
    return s[PW-1:0];
  endfunction

  hed_pkg::item_t                    buf_r [ENTITY_WINDOW];
  logic [PW-1:0]                     start_r, start_nxt;
  logic [OW-1:0]                     sofs_r, sofs_nxt;
  logic [OW-1:0]                     eofs_r, eofs_nxt;
  logic                              last_r;
  logic [hed_pkg::NAME_NUM-1:0]      flags_r, flags_nxt;
  logic                              num_r, num_nxt;
  logic                              hex_r, hex_nxt;
  logic                              bad_r, bad_nxt;
  logic [7:0]                        code_r, code_nxt;
  logic                              out_valid_r;
  logic [7:0]                        out_byte_r;
  logic                              out_last_r;

  logic                              go, caught, flush, from_q, act;
  logic [PW-1:0]                     rd_addr, wr_addr;
  hed_pkg::item_t                    cur;
  logic [OW-1:0]                     eofs_in, nidx;
  logic                              eff_last, room, upd;
  logic                              named_hit, hit;
  logic [7:0]                        named_val, res;
  logic                              emit;
  logic [7:0]                        emit_byte;
  logic [10:0]                       dec_sum;
  logic [11:0]                       hex_sum;

  always_comb begin
    go       = !out_valid_r || !out_stall;
    caught   = (sofs_r == eofs_r);
    flush    = caught && last_r && (sofs_r != '0);
    from_q   = caught && !flush && q_valid;
    act      = go && (flush || from_q || !caught);
    rd_addr  = wrap((OW+1)'(start_r) + (OW+1)'(sofs_r));
    wr_addr  = wrap((OW+1)'(start_r) + (OW+1)'(eofs_r));
    cur      = from_q ? q_item : buf_r[rd_addr];
    eofs_in  = eofs_r + OW'(from_q);
    eff_last = from_q ? q_item.last : last_r;
    nidx     = sofs_r - OW'(1);
    room     = ((OW+1)'(sofs_r) + (OW+1)'(1)) < (OW+1)'(ENTITY_WINDOW);

    named_hit = 1'b0;
    named_val = 8'h00;
    for (int k = 0; k < hed_pkg::NAME_NUM; k++) begin
      if (flags_r[k] && (OW'(hed_pkg::NAME_LEN[k]) == nidx)) begin
        named_hit = 1'b1;
        named_val = hed_pkg::NAME_VAL[k];
      end
    end
    hit = (sofs_r >= OW'(2)) &&
          (num_r ? (!bad_r && (code_r < hed_pkg::CODE_SAT)) : named_hit);
    res = num_r ? code_r : named_val;

    start_nxt = start_r;
    sofs_nxt  = sofs_r;
    eofs_nxt  = eofs_r;
    emit      = 1'b0;
    emit_byte = cur.data;
    upd       = 1'b0;

    if (act) begin
      if (flush) begin
        emit      = 1'b1;
        emit_byte = buf_r[start_r].data;
        start_nxt = wrap((OW+1)'(start_r) + (OW+1)'(1));
        sofs_nxt  = sofs_r - OW'(1);
        eofs_nxt  = eofs_r - OW'(1);
      end else if (sofs_r == '0) begin
        if (cur.is_amp) begin
          sofs_nxt = OW'(1);
          eofs_nxt = eofs_in;
        end else begin
          emit      = 1'b1;
          start_nxt = wrap((OW+1)'(start_r) + (OW+1)'(1));
          eofs_nxt  = eofs_in - OW'(1);
        end
      end else if (cur.is_semi && hit) begin
        emit      = 1'b1;
        emit_byte = res;
        start_nxt = wrap((OW+1)'(start_r) + (OW+1)'(sofs_r) + (OW+1)'(1));
        sofs_nxt  = '0;
        eofs_nxt  = eofs_in - sofs_r - OW'(1);
      end else if (!cur.is_semi && room) begin
        sofs_nxt = sofs_r + OW'(1);
        eofs_nxt = eofs_in;
        upd      = 1'b1;
      end else begin
        // failed match: '&' goes out, the rest is scanned again
        emit      = 1'b1;
        emit_byte = hed_pkg::CH_AMP;
        start_nxt = wrap((OW+1)'(start_r) + (OW+1)'(1));
        sofs_nxt  = '0;
        eofs_nxt  = eofs_in - OW'(1);
      end
    end

    dec_sum = 11'(code_r) * 11'd10 + 11'(cur.dig);
    hex_sum = {code_r, 4'h0} + 12'(cur.hexv);

    flags_nxt = flags_r;
    num_nxt   = num_r;
    hex_nxt   = hex_r;
    bad_nxt   = bad_r;
    code_nxt  = code_r;
    if (upd) begin
      if (sofs_r == OW'(1)) begin
        for (int k = 0; k < hed_pkg::NAME_NUM; k++) begin
          flags_nxt[k] = (cur.data == hed_pkg::NAME_CHAR[k][0]);
        end
        num_nxt  = cur.is_hash;
        hex_nxt  = 1'b0;
        bad_nxt  = 1'b0;
        code_nxt = 8'h00;
      end else begin
        for (int k = 0; k < hed_pkg::NAME_NUM; k++) begin
          flags_nxt[k] = flags_r[k] && (nidx < OW'(hed_pkg::NAME_LEN[k])) &&
                         (cur.data == hed_pkg::NAME_CHAR[k][nidx[1:0]]);
        end
        if (num_r) begin
          if ((nidx == OW'(1)) && cur.is_x) begin
            hex_nxt = 1'b1;
          end else if (hex_r) begin
            code_nxt = (hex_sum >= 12'd128) ? hed_pkg::CODE_SAT : hex_sum[7:0];
          end else if (!cur.is_dig) begin
            bad_nxt = 1'b1;
          end else begin
            code_nxt = (dec_sum >= 11'd128) ? hed_pkg::CODE_SAT : dec_sum[7:0];
          end
        end
      end
    end
  end

  assign q_pop     = act && from_q;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign stat.sofs = 5'(sofs_r);
  assign stat.eofs = 5'(eofs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      sofs_r      <= '0;
      eofs_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= start_nxt;
      sofs_r  <= sofs_nxt;
      eofs_r  <= eofs_nxt;
      if (q_pop) begin
        last_r <= q_item.last;
      end
      if (go) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
    num_r   <= num_nxt;
    hex_r   <= hex_nxt;
    bad_r   <= bad_nxt;
    code_r  <= code_nxt;
    if (q_pop) begin
      buf_r[wr_addr] <= q_item;
    end
    if (go && emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= eff_last && (sofs_nxt == '0) && (eofs_nxt == '0);
    end
  end

endmodule
